@@ sv/assert_macros.svh @@
// Assertion macros shared by the RTL of the direction angle unit.
// Depends on nothing; the assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

@@ sv/dad_pkg.sv @@
// Types and constants of the direction angle unit.
// Used by every module of the unit; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dad_pkg;

  localparam int XY_W         = 44;
  localparam int NORM_BITS    = 41;
  localparam int NORM_STAGES  = 6;
  localparam int CORDIC_STEPS = 30;
  localparam int TURN_W       = 33;
  localparam int ATAN_W       = 30;
  localparam int PROD_W       = 42;

  localparam logic [TURN_W-1:0] QUARTER = 33'h0_4000_0000;
  localparam logic [TURN_W-1:0] HALF    = 33'h0_8000_0000;
  localparam logic [TURN_W-1:0] THREE_Q = 33'h0_C000_0000;
  localparam logic [TURN_W-1:0] TURN    = 33'h1_0000_0000;

  localparam logic [ATAN_W-1:0] ATAN_TABLE [CORDIC_STEPS] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
    30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
    30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
    30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
    30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
    30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
  };

  typedef struct packed {
    logic valid;
    logic dx_zero;
    logic dy_zero;
    logic dx_neg;
    logic dy_neg;
  } dad_ctrl_t;

endpackage

`default_nettype wire

@@ sv/dad_front.sv @@
// Front end: forms dx and dy, then their magnitudes and sign flags.
// Two registered stages; depends on dad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dad_front #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         valid_in,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [COORD_BITS-1:0] end_x,
  input  wire logic signed [COORD_BITS-1:0] end_y,
  output dad_pkg::dad_ctrl_t                ctrl,
  output logic [dad_pkg::XY_W-1:0]          ax,
  output logic [dad_pkg::XY_W-1:0]          ay
);
  import dad_pkg::*;

  logic                    diff_valid;
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS:0]     ax_mag;
  logic [COORD_BITS:0]     ay_mag;

  assign ax_mag = dx[COORD_BITS] ? $unsigned(-dx) : $unsigned(dx);
  assign ay_mag = dy[COORD_BITS] ? $unsigned(-dy) : $unsigned(dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
      ctrl       <= '0;
    end else if (en) begin
      diff_valid    <= valid_in;
      ctrl.valid    <= diff_valid;
      ctrl.dx_zero  <= (dx == '0);
      ctrl.dy_zero  <= (dy == '0);
      ctrl.dx_neg   <= dx[COORD_BITS];
      ctrl.dy_neg   <= dy[COORD_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
      dy <= {start_y[COORD_BITS-1], start_y} - {end_y[COORD_BITS-1], end_y};
      ax <= {{(XY_W-COORD_BITS-1){1'b0}}, ax_mag};
      ay <= {{(XY_W-COORD_BITS-1){1'b0}}, ay_mag};
    end
  end

endmodule

`default_nettype wire

@@ sv/dad_norm_cell.sv @@
// One normalizing cell: shifts both magnitudes left by a fixed amount when
// the larger one stays below the normalized limit. Depends on dad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dad_norm_cell #(
  parameter int SHIFT = 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire dad_pkg::dad_ctrl_t          ctrl_in,
  input  wire logic [dad_pkg::XY_W-1:0]    ax_in,
  input  wire logic [dad_pkg::XY_W-1:0]    ay_in,
  output dad_pkg::dad_ctrl_t               ctrl,
  output logic [dad_pkg::XY_W-1:0]         ax,
  output logic [dad_pkg::XY_W-1:0]         ay
);
  import dad_pkg::*;

  localparam int LIM = NORM_BITS - SHIFT;

  logic fits;

  assign fits = (((ax_in | ay_in) >> LIM) == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (en) begin
      ctrl <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax <= fits ? (ax_in << SHIFT) : ax_in;
      ay <= fits ? (ay_in << SHIFT) : ay_in;
    end
  end

endmodule

`default_nettype wire

@@ sv/dad_cordic_cell.sv @@
// One vectoring CORDIC micro-rotation with its own shift and arctangent step.
// Depends on dad_pkg for widths and the arctangent table.
`timescale 1ns / 1ps
`default_nettype none

module dad_cordic_cell #(
  parameter int IDX = 0
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire dad_pkg::dad_ctrl_t                 ctrl_in,
  input  wire logic signed [dad_pkg::XY_W-1:0]    x_in,
  input  wire logic signed [dad_pkg::XY_W-1:0]    y_in,
  input  wire logic signed [dad_pkg::TURN_W-1:0]  z_in,
  output dad_pkg::dad_ctrl_t                      ctrl,
  output logic signed [dad_pkg::XY_W-1:0]         x,
  output logic signed [dad_pkg::XY_W-1:0]         y,
  output logic signed [dad_pkg::TURN_W-1:0]       z
);
  import dad_pkg::*;

  localparam logic signed [TURN_W-1:0] ANG =
    $signed({{(TURN_W-ATAN_W){1'b0}}, ATAN_TABLE[IDX]});

  logic signed [XY_W-1:0] xs;
  logic signed [XY_W-1:0] ys;

  assign xs = x_in >>> IDX;
  assign ys = y_in >>> IDX;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= '0;
    end else if (en) begin
      ctrl <= ctrl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_in[XY_W-1]) begin
        x <= x_in + ys;
        y <= y_in - xs;
        z <= z_in + ANG;
      end else begin
        x <= x_in - ys;
        y <= y_in + xs;
        z <= z_in - ANG;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/dad_back.sv @@
// Back end: clamps the first-quadrant angle, places it in its quadrant,
// scales the binary angle to rounded degrees and wraps a full turn to zero.
// Two registered stages; depends on dad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dad_back #(
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               en,
  input  wire dad_pkg::dad_ctrl_t                 ctrl_in,
  input  wire logic signed [dad_pkg::TURN_W-1:0]  z_in,
  output logic                                    valid,
  output logic [ANGLE_FRAC_BITS+8:0]              result
);
  import dad_pkg::*;

  localparam int DEG_W = ANGLE_FRAC_BITS + 10;
  localparam int OUT_W = ANGLE_FRAC_BITS + 9;
  localparam logic [DEG_W-1:0]  FULL  = DEG_W'(360 * (2 ** ANGLE_FRAC_BITS));
  localparam logic [PROD_W-1:0] ROUND = PROD_W'(1) << (31 - ANGLE_FRAC_BITS);

  logic               a_valid;
  logic [TURN_W-1:0]  t;
  logic [TURN_W-1:0]  a_next;
  logic [TURN_W-1:0]  a;
  logic [PROD_W-1:0]  prod;
  logic [DEG_W-1:0]   deg;
  logic [DEG_W-1:0]   wrapped;

  always_comb begin
    if (z_in[TURN_W-1]) begin
      t = '0;
    end else if ($unsigned(z_in) > QUARTER) begin
      t = QUARTER;
    end else begin
      t = $unsigned(z_in);
    end
    if (ctrl_in.dx_zero) begin
      if (ctrl_in.dy_zero) begin
        a_next = '0;
      end else if (ctrl_in.dy_neg) begin
        a_next = THREE_Q;
      end else begin
        a_next = QUARTER;
      end
    end else if (ctrl_in.dy_zero) begin
      a_next = ctrl_in.dx_neg ? HALF : '0;
    end else if (!ctrl_in.dx_neg && !ctrl_in.dy_neg) begin
      a_next = t;
    end else if (ctrl_in.dx_neg && !ctrl_in.dy_neg) begin
      a_next = HALF - t;
    end else if (ctrl_in.dx_neg) begin
      a_next = HALF + t;
    end else begin
      a_next = TURN - t;
    end
  end

  assign prod    = {{(PROD_W-TURN_W){1'b0}}, a} * PROD_W'(360) + ROUND;
  assign wrapped = (deg >= FULL) ? (deg - FULL) : deg;
  assign result  = wrapped[OUT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      valid   <= 1'b0;
    end else if (en) begin
      a_valid <= ctrl_in.valid;
      valid   <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a   <= a_next;
      deg <= prod[PROD_W-1:32-ANGLE_FRAC_BITS];
    end
  end

endmodule

`default_nettype wire

@@ sv/direction_angle_degrees_unit.sv @@
// Direction of the vector from start to end (screen y grows downward) as an
// angle in degrees in [0, 360) with ANGLE_FRAC_BITS fraction bits, rounded.
// One item is accepted every cycle while the skid buffer is empty; each item
// passes through two front stages, six normalizing cells, thirty CORDIC
// cells, two scaling stages and the output register. A one-item skid buffer
// behind the output register takes a result that arrives while the output is
// stalled; intake pauses only when both hold an item.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module direction_angle_degrees_unit #(
  parameter int COORD_BITS      = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [COORD_BITS-1:0] start_x,
  input  wire logic signed [COORD_BITS-1:0] start_y,
  input  wire logic signed [COORD_BITS-1:0] end_x,
  input  wire logic signed [COORD_BITS-1:0] end_y,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [ANGLE_FRAC_BITS+8:0]        angle_deg
);
  import dad_pkg::*;

  localparam int OUT_W = ANGLE_FRAC_BITS + 9;

  logic                      en;
  dad_ctrl_t                 nc [NORM_STAGES+1];
  logic [XY_W-1:0]           nx [NORM_STAGES+1];
  logic [XY_W-1:0]           ny [NORM_STAGES+1];
  dad_ctrl_t                 cc [CORDIC_STEPS+1];
  logic signed [XY_W-1:0]    cx [CORDIC_STEPS+1];
  logic signed [XY_W-1:0]    cy [CORDIC_STEPS+1];
  logic signed [TURN_W-1:0]  cz [CORDIC_STEPS+1];
  logic                      res_valid;
  logic [OUT_W-1:0]          res;
  logic                      skid_valid;
  logic [OUT_W-1:0]          skid;

  assign en       = !skid_valid;
  assign in_ready = en;

  dad_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .valid_in(in_valid),
    .start_x (start_x),
    .start_y (start_y),
    .end_x   (end_x),
    .end_y   (end_y),
    .ctrl    (nc[0]),
    .ax      (nx[0]),
    .ay      (ny[0])
  );

  for (genvar k = 0; k < NORM_STAGES; k++) begin : g_norm
    dad_norm_cell #(
      .SHIFT(2 ** (NORM_STAGES - 1 - k))
    ) u_norm (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .ctrl_in(nc[k]),
      .ax_in  (nx[k]),
      .ay_in  (ny[k]),
      .ctrl   (nc[k+1]),
      .ax     (nx[k+1]),
      .ay     (ny[k+1])
    );
  end

  assign cc[0] = nc[NORM_STAGES];
  assign cx[0] = $signed(nx[NORM_STAGES]);
  assign cy[0] = $signed(ny[NORM_STAGES]);
  assign cz[0] = '0;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    dad_cordic_cell #(
      .IDX(i)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (en),
      .ctrl_in(cc[i]),
      .x_in   (cx[i]),
      .y_in   (cy[i]),
      .z_in   (cz[i]),
      .ctrl   (cc[i+1]),
      .x      (cx[i+1]),
      .y      (cy[i+1]),
      .z      (cz[i+1])
    );
  end

  dad_back #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .ctrl_in(cc[CORDIC_STEPS]),
    .z_in   (cz[CORDIC_STEPS]),
    .valid  (res_valid),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid  <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end else if (!skid_valid && res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      angle_deg <= skid_valid ? skid : res;
    end else if (!skid_valid) begin
      skid <= res;
    end
  end

  `ASSERT_IMPLIES(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `ASSERT_IMPLIES(a_skid_fills_on_stall, clk, rst, $rose(skid_valid), $past(out_valid && !out_ready))
  `ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && out_ready, !skid_valid && out_valid)
  `ASSERT_IMPLIES(a_below_turn, clk, rst, out_valid, angle_deg < OUT_W'(360 * (2 ** ANGLE_FRAC_BITS)))

endmodule

`default_nettype wire

@@ dv/direction_angle_check.sv @@
// Checker for the direction angle unit: watches both channels, predicts each angle
// with a 30-step CORDIC in vectoring mode and compares the results in order.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module direction_angle_check #(
  parameter int COORD_BITS      = 16,
  parameter int ANGLE_FRAC_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [ANGLE_FRAC_BITS+8:0]   angle_deg,
  output int                           mismatches,
  output int                           outstanding
);

  localparam int     ROT_STEPS = 30;
  localparam int     DUE_DEPTH = 64;
  localparam longint QTR       = 64'sd1 << 30;
  localparam longint NORM_MIN  = 64'sd1 << 40;
  localparam longint ATAN_STEP [ROT_STEPS] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
  };

  logic [ANGLE_FRAC_BITS+8:0] angle_due [DUE_DEPTH];
  logic [5:0]                 due_wr;
  logic [5:0]                 due_rd;
  int                         due_count;
  logic [ANGLE_FRAC_BITS+8:0] want;

  initial mismatches = 0;
  initial outstanding = 0;
  initial due_wr = '0;
  initial due_rd = '0;
  initial due_count = 0;

  // Angles are binary angles of 2^32 per turn until the final scaling to degrees.
  function automatic logic [ANGLE_FRAC_BITS+8:0] heading_fixed(
    input logic signed [COORD_BITS-1:0] sx,
    input logic signed [COORD_BITS-1:0] sy,
    input logic signed [COORD_BITS-1:0] ex,
    input logic signed [COORD_BITS-1:0] ey
  );
    longint dx, dy, x, y, z, xs, ys, a, deg;
    int i;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(sy) - longint'(ey);
    if (dx == 0) begin
      a = (dy > 0) ? QTR : (dy < 0) ? 3 * QTR : 64'sd0;
    end else if (dy == 0) begin
      a = (dx > 0) ? 64'sd0 : 2 * QTR;
    end else begin
      x = (dx < 0) ? -dx : dx;
      y = (dy < 0) ? -dy : dy;
      z = 0;
      while (x < NORM_MIN && y < NORM_MIN) begin
        x = x <<< 1;
        y = y <<< 1;
      end
      for (i = 0; i < ROT_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + ATAN_STEP[i];
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - ATAN_STEP[i];
        end
      end
      if (z < 0) z = 0;
      if (z > QTR) z = QTR;
      if (dx > 0 && dy > 0) a = z;
      else if (dx < 0 && dy > 0) a = 2 * QTR - z;
      else if (dx < 0) a = 2 * QTR + z;
      else a = 4 * QTR - z;
    end
    deg = (a * 360 + (64'sd1 << (31 - ANGLE_FRAC_BITS))) >>> (32 - ANGLE_FRAC_BITS);
    if (deg >= (64'sd360 << ANGLE_FRAC_BITS)) deg = deg - (64'sd360 << ANGLE_FRAC_BITS);
    return deg[ANGLE_FRAC_BITS+8:0];
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        angle_due[due_wr] = heading_fixed(start_x, start_y, end_x, end_y);
        due_wr = due_wr + 6'd1;
        due_count++;
      end
      if (out_valid && out_ready) begin
        if (due_count == 0) begin
          $error("angle_deg: no item expected, actual %0d", angle_deg);
          mismatches++;
        end else begin
          want = angle_due[due_rd];
          due_rd = due_rd + 6'd1;
          due_count--;
          if (angle_deg !== want) begin
            $error("angle_deg: expected %0d, actual %0d", want, angle_deg);
            mismatches++;
          end
        end
      end
      outstanding <= due_count;
    end
  end

endmodule

@@ dv/tb.sv @@
// Top of the direction angle unit testbench: clock, reset, stimulus and verdict.
// Depends on direction_angle_check.sv and on the unit's RTL.
`timescale 1ns / 1ps

module tb;

  localparam int COORD_BITS      = 16;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 60;
  localparam int PHASE_ITEMS     = 160;

  logic                         clk;
  logic                         rst       = 1'b1;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  logic signed [COORD_BITS-1:0] start_x   = '0;
  logic signed [COORD_BITS-1:0] start_y   = '0;
  logic signed [COORD_BITS-1:0] end_x     = '0;
  logic signed [COORD_BITS-1:0] end_y     = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [ANGLE_FRAC_BITS+8:0]   angle_deg;

  int          mismatches;
  int          outstanding;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int unsigned cycle_count   = 0;

  direction_angle_degrees_unit #(
    .COORD_BITS     (COORD_BITS),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x    (end_x),
    .end_y    (end_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .angle_deg(angle_deg)
  );

  direction_angle_check #(
    .COORD_BITS     (COORD_BITS),
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) i_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .angle_deg  (angle_deg),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_points(
    input logic signed [COORD_BITS-1:0] sx,
    input logic signed [COORD_BITS-1:0] sy,
    input logic signed [COORD_BITS-1:0] ex,
    input logic signed [COORD_BITS-1:0] ey
  );
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    start_x  <= sx;
    start_y  <= sy;
    end_x    <= ex;
    end_y    <= ey;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mix of free points, short vectors, axis-aligned, diagonal and near-axis vectors.
  task automatic send_random_vector();
    logic signed [COORD_BITS-1:0] sx, sy, ex, ey, span;
    int kind;
    kind = $urandom_range(0, 9);
    sx = COORD_BITS'($urandom);
    sy = COORD_BITS'($urandom);
    ex = COORD_BITS'($urandom);
    ey = COORD_BITS'($urandom);
    span = COORD_BITS'($urandom_range(0, 4000));
    case (kind)
      4, 5: begin
        ex = sx + COORD_BITS'($urandom_range(0, 8)) - COORD_BITS'(4);
        ey = sy + COORD_BITS'($urandom_range(0, 8)) - COORD_BITS'(4);
      end
      6: begin
        if ($urandom_range(0, 1)) ex = sx;
        else ey = sy;
      end
      7: begin
        ex = $urandom_range(0, 1) ? sx + span : sx - span;
        ey = $urandom_range(0, 1) ? sy + span : sy - span;
      end
      8, 9: begin
        if ($urandom_range(0, 1)) ey = sy + COORD_BITS'($urandom_range(0, 4)) - COORD_BITS'(2);
        else ex = sx + COORD_BITS'($urandom_range(0, 4)) - COORD_BITS'(2);
      end
      default: ;
    endcase
    send_points(sx, sy, ex, ey);
  endtask

  initial begin
    int n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_points(0, 0, 0, 0);
    send_points(32767, -32768, 32767, -32768);
    send_points(-1, -1, -1, -1);
    send_points(0, 10, 0, -5);
    send_points(0, -5, 0, 10);
    send_points(-32768, 32767, -32768, -32768);
    send_points(5, -32768, 5, 32767);
    send_points(-32768, 0, 32767, 0);
    send_points(32767, 5, -32768, 5);
    send_points(-32768, 32767, 32767, -32768);
    send_points(32767, 32767, -32768, -32768);
    send_points(32767, -32768, -32768, 32767);
    send_points(-32768, -32768, 32767, 32767);
    send_points(-32768, 0, 32767, 1);
    send_points(32767, 0, -32768, -1);
    send_points(0, 32767, 1, -32768);
    send_points(0, -32768, 1, 32767);
    send_points(0, 0, 1, -1);
    send_points(0, 0, -1, -1);
    send_points(0, 0, -1, 1);
    send_points(0, 0, 1, 1);
    send_points(21845, -21846, -21846, 21845);

    for (n = 0; n < PHASE_ITEMS; n++) send_random_vector();
    send_idle_pct = 80;
    for (n = 0; n < PHASE_ITEMS; n++) send_random_vector();
    send_idle_pct = 0;
    stall_pct <= 80;
    for (n = 0; n < PHASE_ITEMS; n++) send_random_vector();
    send_idle_pct = 11;
    stall_pct <= 11;
    for (n = 0; n < PHASE_ITEMS; n++) send_random_vector();
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
